### sv/assert_macros.svh
// Assertion macros shared by the RTL of the reply frame deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Whenever cond_a holds, cond_b holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error("assertion failed");

// cond_a holds in one cycle, then cond_b holds in the next one.
`define ASSERT_NEXT(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, cond_a, cond_b)
`define ASSERT_NEXT(label, clk, rst, cond_a, cond_b)

`endif

`endif

### sv/rfdx_pkg.sv
// Types and codes of the reply frame deframer.
`timescale 1ns / 1ps

package rfdx_pkg;

   typedef enum logic [2:0] {
      CSR_HEADER_BYTE   = 3'd0,
      CSR_EXPECTED_SEQ  = 3'd1,
      CSR_REQUEST_KIND  = 3'd2,
      CSR_EXPECTED_SUB  = 3'd3,
      CSR_ACTION_CODE   = 3'd4,
      CSR_CHECK_CODE    = 3'd5,
      CSR_CONNECT_CODE  = 3'd6,
      CSR_IDENTIFY_CODE = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ACTION   = 3'd0,
      KIND_CHECK    = 3'd1,
      KIND_CONNECT  = 3'd2,
      KIND_IDENTIFY = 3'd3,
      KIND_OTHER    = 3'd4
   } request_kind_type;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   localparam int unsigned BYTE_W = 8;
   localparam logic [BYTE_W-1:0] LEN_POS = 8'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      logic [BYTE_W-1:0] byte_position;
      logic              byte_kept;
      verdict_type       verdict;
      logic [BYTE_W-1:0] frame_length;
      logic [BYTE_W-1:0] payload_length;
   } result_type;

endpackage

### sv/reply_frame_deframer_xor_unit.sv
// Top level of the reply frame deframer with running XOR checksum.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Reply frame deframer.
// req_* carries received bytes, one per transfer; rsp_* returns one result per
// byte: the echoed byte, its frame position, a kept flag, and at the checksum
// byte the verdict with frame and payload lengths of an accepted frame.
// csr_* writes the eight setup registers (index 0..7); csr_ready is always high.
// Write them only while no byte is in flight.
// The result of a taken byte is registered: in the result register, or in the skid while rsp_* is stalled.
// Throughput: one byte per cycle while req_stall is low; the frame state (position, length, XOR,
// captured fields) updates in the same cycle a byte is taken.
// A result register plus a one-entry skid register sit on the output: when
// rsp_stall holds, one more byte is still taken into the skid, then req_stall
// rises until the skid drains.
// Reset (synchronous, active high) returns to header hunt, empties the output
// and sets request kind to "other" so every frame rejects until configured.
module reply_frame_deframer_xor_unit
   import rfdx_pkg::*;
#(
   parameter int unsigned MAX_FRAME_LEN = 200,
   parameter int unsigned SEQ_POS       = 3,
   parameter int unsigned TYPE_POS      = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_echo_byte,
   output logic [BYTE_W-1:0]   rsp_byte_position,
   output logic                rsp_byte_kept,
   output logic [1:0]          rsp_verdict,
   output logic [BYTE_W-1:0]   rsp_frame_length,
   output logic [BYTE_W-1:0]   rsp_payload_length,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [BYTE_W-1:0]   csr_data
);

   localparam logic [BYTE_W-1:0] MAX_LEN  = BYTE_W'(MAX_FRAME_LEN);
   localparam logic [BYTE_W-1:0] SEQ_AT   = BYTE_W'(SEQ_POS);
   localparam logic [BYTE_W-1:0] TYPE_AT  = BYTE_W'(TYPE_POS);
   localparam logic [BYTE_W-1:0] SUB_AT   = BYTE_W'(TYPE_POS + 1);

   // setup registers
   logic [BYTE_W-1:0] header_byte_ff, expected_seq_ff, expected_sub_ff;
   logic [BYTE_W-1:0] action_code_ff, check_code_ff, connect_code_ff, identify_code_ff;
   logic [2:0]        request_kind_ff;

   // frame state
   logic [BYTE_W-1:0] position_ff, position_in;
   logic [BYTE_W-1:0] declared_len_ff, declared_len_in;
   logic [BYTE_W-1:0] running_xor_ff, running_xor_in;
   logic [BYTE_W-1:0] seen_seq_ff, seen_seq_in;
   logic [BYTE_W-1:0] seen_type_ff, seen_type_in;
   logic [BYTE_W-1:0] seen_sub_ff, seen_sub_in;

   // output side
   logic       rsp_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff, result;

   logic req_take, out_free, reply_ok;
   logic [BYTE_W-1:0] b;

   assign b         = req_rx_byte;
   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff   <= '0;
         expected_seq_ff  <= '0;
         request_kind_ff  <= KIND_OTHER;
         expected_sub_ff  <= '0;
         action_code_ff   <= '0;
         check_code_ff    <= '0;
         connect_code_ff  <= '0;
         identify_code_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_BYTE:   header_byte_ff   <= csr_data;
            CSR_EXPECTED_SEQ:  expected_seq_ff  <= csr_data;
            CSR_REQUEST_KIND:  request_kind_ff  <= csr_data[2:0];
            CSR_EXPECTED_SUB:  expected_sub_ff  <= csr_data;
            CSR_ACTION_CODE:   action_code_ff   <= csr_data;
            CSR_CHECK_CODE:    check_code_ff    <= csr_data;
            CSR_CONNECT_CODE:  connect_code_ff  <= csr_data;
            CSR_IDENTIFY_CODE: identify_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (request_kind_ff)
         KIND_ACTION:   reply_ok = (seen_type_in == action_code_ff)
                                   && (seen_sub_in == expected_sub_ff);
         KIND_CHECK:    reply_ok = (seen_type_in == check_code_ff)
                                   && (seen_sub_in == expected_sub_ff);
         KIND_CONNECT:  reply_ok = (seen_type_in == connect_code_ff);
         KIND_IDENTIFY: reply_ok = (seen_type_in == identify_code_ff);
         default:       reply_ok = 1'b0;
      endcase
   end

   always_comb begin
      position_in     = position_ff;
      declared_len_in = declared_len_ff;
      running_xor_in  = running_xor_ff;
      // capture of sequence, type and subtype by position
      seen_seq_in     = (position_ff == SEQ_AT)  ? b : seen_seq_ff;
      seen_type_in    = (position_ff == TYPE_AT) ? b : seen_type_ff;
      seen_sub_in     = (position_ff == SUB_AT)  ? b : seen_sub_ff;

      result.echo_byte      = b;
      result.byte_position  = '0;
      result.byte_kept      = 1'b0;
      result.verdict        = VERDICT_NONE;
      result.frame_length   = '0;
      result.payload_length = '0;

      if (position_ff == '0) begin
         if (b == header_byte_ff) begin
            result.byte_kept = 1'b1;
            running_xor_in   = b;
            position_in      = LEN_POS;
         end
      end else if (position_ff == LEN_POS) begin
         if (b > MAX_LEN || b <= TYPE_AT) begin
            position_in = '0;
         end else begin
            result.byte_position = position_ff;
            result.byte_kept     = 1'b1;
            declared_len_in      = b;
            running_xor_in       = running_xor_ff ^ b;
            position_in          = position_ff + 1'b1;
         end
      end else if (position_ff >= declared_len_ff) begin
         // checksum byte closes the frame
         result.byte_position = position_ff;
         result.byte_kept     = 1'b1;
         if (b == running_xor_ff && seen_seq_in == expected_seq_ff && reply_ok) begin
            result.verdict        = VERDICT_ACCEPT;
            result.frame_length   = position_ff + 1'b1;
            result.payload_length = declared_len_ff - SUB_AT;
         end else begin
            result.verdict = VERDICT_REJECT;
         end
         position_in = '0;
      end else begin
         result.byte_position = position_ff;
         result.byte_kept     = 1'b1;
         running_xor_in       = running_xor_ff ^ b;
         position_in          = position_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         declared_len_ff <= '0;
         running_xor_ff  <= '0;
         seen_seq_ff     <= '0;
         seen_type_ff    <= '0;
         seen_sub_ff     <= '0;
      end else if (req_take) begin
         position_ff     <= position_in;
         declared_len_ff <= declared_len_in;
         running_xor_ff  <= running_xor_in;
         seen_seq_ff     <= seen_seq_in;
         seen_type_ff    <= seen_type_in;
         seen_sub_ff     <= seen_sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_take;
         end
      end else if (req_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_take) begin
            out_ff <= result;
         end
      end else if (req_take) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_byte      = out_ff.echo_byte;
   assign rsp_byte_position  = out_ff.byte_position;
   assign rsp_byte_kept      = out_ff.byte_kept;
   assign rsp_verdict        = out_ff.verdict;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_payload_length = out_ff.payload_length;

   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_IMPLY(a_verdict_kept, clock, reset,
      rsp_valid_ff && out_ff.verdict != VERDICT_NONE, out_ff.byte_kept)
   `ASSERT_IMPLY(a_len_on_accept, clock, reset,
      rsp_valid_ff && out_ff.frame_length != '0, out_ff.verdict == VERDICT_ACCEPT)
   `ASSERT_NEXT(a_close_rehunt, clock, reset,
      req_take && result.verdict != VERDICT_NONE, position_ff == '0)

endmodule

### verif/tb_reply_frame_deframer_xor_unit.sv
// Testbench for the reply frame deframer: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_reply_frame_deframer_xor_unit;
   import rfdx_pkg::*;

   localparam int MAX_LEN     = 200;
   localparam int SEQ_P       = 3;
   localparam int TYPE_P      = 4;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [BYTE_W-1:0] rsp_echo_byte;
   logic [BYTE_W-1:0] rsp_byte_position;
   logic              rsp_byte_kept;
   logic [1:0]        rsp_verdict;
   logic [BYTE_W-1:0] rsp_frame_length;
   logic [BYTE_W-1:0] rsp_payload_length;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [BYTE_W-1:0] csr_data = '0;

   // register copies
   logic [7:0] cfg_header   = 8'h00;
   logic [7:0] cfg_seq      = 8'h00;
   logic [2:0] cfg_kind     = KIND_OTHER;
   logic [7:0] cfg_sub      = 8'h00;
   logic [7:0] cfg_action   = 8'h00;
   logic [7:0] cfg_check    = 8'h00;
   logic [7:0] cfg_connect  = 8'h00;
   logic [7:0] cfg_identify = 8'h00;

   // frame state
   logic [7:0] frm_pos  = 8'h00;
   logic [7:0] frm_len  = 8'h00;
   logic [7:0] frm_xor  = 8'h00;
   logic [7:0] got_seq  = 8'h00;
   logic [7:0] got_type = 8'h00;
   logic [7:0] got_sub  = 8'h00;

   result_type expected_results[$];
   int n_errors      = 0;
   int n_sent        = 0;
   int n_setups      = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;

   reply_frame_deframer_xor_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_byte_kept      (rsp_byte_kept),
      .rsp_verdict        (rsp_verdict),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic reply_ok();
      case (cfg_kind)
         KIND_ACTION:   return got_type == cfg_action && got_sub == cfg_sub;
         KIND_CHECK:    return got_type == cfg_check && got_sub == cfg_sub;
         KIND_CONNECT:  return got_type == cfg_connect;
         KIND_IDENTIFY: return got_type == cfg_identify;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic void capture_field(input logic [7:0] b);
      if (frm_pos == SEQ_P) got_seq = b;
      if (frm_pos == TYPE_P) got_type = b;
      if (frm_pos == TYPE_P + 1) got_sub = b;
   endfunction

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.echo_byte = b;
      r.verdict = VERDICT_NONE;
      if (frm_pos == 0) begin
         if (b == cfg_header) begin
            r.byte_kept = 1'b1;
            frm_xor = b;
            frm_pos = 8'd1;
         end
      end else if (frm_pos == LEN_POS) begin
         if (b > MAX_LEN || b <= TYPE_P) begin
            frm_pos = 8'd0;
         end else begin
            r.byte_position = frm_pos;
            r.byte_kept = 1'b1;
            frm_len = b;
            frm_xor = frm_xor ^ b;
            frm_pos = frm_pos + 8'd1;
         end
      end else if (frm_pos >= frm_len) begin
         r.byte_position = frm_pos;
         r.byte_kept = 1'b1;
         capture_field(b);
         if (b == frm_xor && got_seq == cfg_seq && reply_ok()) begin
            r.verdict = VERDICT_ACCEPT;
            r.frame_length = frm_pos + 8'd1;
            r.payload_length = 8'(frm_len - TYPE_P - 1);
         end else begin
            r.verdict = VERDICT_REJECT;
         end
         frm_pos = 8'd0;
      end else begin
         r.byte_position = frm_pos;
         r.byte_kept = 1'b1;
         capture_field(b);
         frm_xor = frm_xor ^ b;
         frm_pos = frm_pos + 8'd1;
      end
      return r;
   endfunction

   function automatic logic [7:0] reply_code();
      case (cfg_kind)
         KIND_ACTION:   return cfg_action;
         KIND_CHECK:    return cfg_check;
         KIND_CONNECT:  return cfg_connect;
         KIND_IDENTIFY: return cfg_identify;
         default:       return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte(input int mode);
      if (mode == 1) return 8'h00;
      if (mode == 2) return 8'hFF;
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with none expected, echo_byte %0d", rsp_echo_byte);
            n_errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("echo_byte", want.echo_byte, rsp_echo_byte);
            check_field("byte_position", want.byte_position, rsp_byte_position);
            check_field("byte_kept", want.byte_kept, rsp_byte_kept);
            check_field("verdict", want.verdict, rsp_verdict);
            check_field("frame_length", want.frame_length, rsp_frame_length);
            check_field("payload_length", want.payload_length, rsp_payload_length);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(deframe_byte(b));
      n_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HEADER_BYTE:   cfg_header = val;
         CSR_EXPECTED_SEQ:  cfg_seq = val;
         CSR_REQUEST_KIND:  cfg_kind = val[2:0];
         CSR_EXPECTED_SUB:  cfg_sub = val;
         CSR_ACTION_CODE:   cfg_action = val;
         CSR_CHECK_CODE:    cfg_check = val;
         CSR_CONNECT_CODE:  cfg_connect = val;
         CSR_IDENTIFY_CODE: cfg_identify = val;
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [7:0] hdr, input logic [7:0] seq,
                              input logic [2:0] kind, input logic [7:0] sub,
                              input logic [7:0] a_code, input logic [7:0] c_code,
                              input logic [7:0] n_code, input logic [7:0] i_code);
      write_reg(CSR_HEADER_BYTE, hdr);
      write_reg(CSR_EXPECTED_SEQ, seq);
      write_reg(CSR_REQUEST_KIND, {5'd0, kind});
      write_reg(CSR_EXPECTED_SUB, sub);
      write_reg(CSR_ACTION_CODE, a_code);
      write_reg(CSR_CHECK_CODE, c_code);
      write_reg(CSR_CONNECT_CODE, n_code);
      write_reg(CSR_IDENTIFY_CODE, i_code);
      csr_valid <= 1'b0;
   endtask

   task automatic random_setup(input int mode);
      logic [2:0] kind;
      kind = (n_setups % 5 < 4) ? 3'(n_setups % 5) : 3'($urandom_range(4, 7));
      n_setups++;
      apply_setup(pick_byte(mode), pick_byte(mode), kind, pick_byte(mode),
                  pick_byte(mode), pick_byte(mode), pick_byte(mode), pick_byte(mode));
   endtask

   // shortest frame: byte 2 is chosen so the checksum equals the subtype
   task automatic send_frame(input logic [7:0] len, input logic [7:0] seq,
                             input logic [7:0] typ, input logic [7:0] sub,
                             input bit bad_cks);
      logic [7:0] fb[$];
      logic [7:0] x;
      fb.push_back(cfg_header);
      fb.push_back(len);
      for (int p = 2; p < len; p++) begin
         if (p == SEQ_P) fb.push_back(seq);
         else if (p == TYPE_P) fb.push_back(typ);
         else if (p == TYPE_P + 1) fb.push_back(sub);
         else fb.push_back(8'($urandom));
      end
      if (len == TYPE_P + 1) fb[2] = cfg_header ^ len ^ seq ^ typ ^ sub;
      x = 8'h00;
      foreach (fb[i]) x = x ^ fb[i];
      if (bad_cks) x = x ^ 8'($urandom_range(1, 255));
      fb.push_back(x);
      foreach (fb[i]) send_byte(fb[i]);
   endtask

   task automatic send_random_frame();
      int r;
      logic [7:0] len;
      logic [7:0] seq;
      logic [7:0] typ;
      logic [7:0] sub;
      if ($urandom_range(99) < 30) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      r = $urandom_range(99);
      if ($urandom_range(99) < 3)
         len = ($urandom_range(3) == 0) ? 8'd200 : 8'($urandom_range(100, 200));
      else
         len = 8'($urandom_range(5, 12));
      seq = cfg_seq;
      typ = reply_code();
      sub = cfg_sub;
      if (r < 12) begin
         send_byte(cfg_header);
         send_byte($urandom_range(1) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(201, 255)));
      end else begin
         if (r < 20) seq = seq ^ 8'($urandom_range(1, 255));
         else if (r < 28) typ = typ ^ 8'($urandom_range(1, 255));
         else if (r < 36) sub = sub ^ 8'($urandom_range(1, 255));
         send_frame(len, seq, typ, sub, r >= 36 && r < 44);
      end
   endtask

   // after reset the request kind is "other", so a well formed frame rejects
   task automatic test_reset_defaults();
      send_frame(8'd5, 8'h00, 8'h00, 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_directed_frames();
      apply_setup(8'hE5, 8'h3C, KIND_ACTION, 8'h81, 8'h11, 8'h22, 8'h33, 8'h44);
      send_frame(8'd6, 8'h3C, 8'h11, 8'h81, 1'b0);
      send_byte(8'hE5);
      send_byte(8'd4);
      // bad length equal to the header is not taken as a new header
      send_byte(8'hE5);
      send_byte(8'hE5);
      send_frame(8'd5, 8'h3C, 8'h11, 8'h81, 1'b0);
      drain_results();
   endtask

   task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int mode);
      int phase_end;
      int next_setup;
      send_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      phase_end = n_sent + 445;
      random_setup(mode);
      next_setup = n_sent + 150;
      while (n_sent < phase_end) begin
         if (n_sent >= next_setup) begin
            drain_results();
            random_setup(0);
            next_setup = n_sent + 150;
         end
         send_random_frame();
      end
      drain_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_frames();
      test_random_phase(26, 73, 1);
      test_random_phase(73, 26, 2);
      test_random_phase(0, 0, 0);
      repeat (10) @(posedge clock);
      if (n_errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
